// ===== rtl/core/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants for the one-shot timer table: command and
// response beats, action and kind codes, controller state and control bundles.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int ID_W     = 8;
  localparam int PERIOD_W = 32;
  localparam int TICKS_W  = 29;
  localparam int REM_W    = 32;

  // action codes
  localparam logic [2:0] ACT_TICK      = 3'd0;
  localparam logic [2:0] ACT_START     = 3'd1;
  localparam logic [2:0] ACT_STOP      = 3'd2;
  localparam logic [2:0] ACT_QUERY     = 3'd3;
  localparam logic [2:0] ACT_RESET_ALL = 3'd4;

  // response kinds
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;

  // at most this many expiry events per tick
  localparam int MAX_EVENTS = 8;
  localparam int EVCNT_W    = 4;

  // period / 10 as (period * magic) >> shift, exact over 32 bits
  localparam logic [PERIOD_W-1:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int                  DIV10_SHIFT = 35;

  typedef struct packed {
    logic [2:0]          action;
    logic [ID_W-1:0]     tmr_id;
    logic [PERIOD_W-1:0] period_ms;
    logic                notify;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ID_W-1:0]  event_id;
    logic             flag;
    logic [REM_W-1:0] remaining_ms;
    logic             last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FINISH,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;    // capture the command beat
    logic rd_en;   // read the slot under the scan index
    logic eval;    // evaluate the slot and advance the scan
    logic finish;  // close out start or query
    logic flush;   // send the held result as the final beat
  } ctl_t;

  typedef struct packed {
    logic last_slot;
    logic stall;
    logic pend_valid;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/stt_ctrl.sv =====
// ----------------------------------------------------------------------------
// stt_ctrl
// Sequencer for the timer table: accepts a command, walks the slots one
// read and one evaluate at a time, then drains the held result.
// ----------------------------------------------------------------------------
module stt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  logic [2:0]     cmd_action,
  input  stt_pkg::stat_t stat,
  output stt_pkg::ctl_t  ctl
);
  import stt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd_action) inside
            ACT_TICK, ACT_START, ACT_STOP, ACT_QUERY: state_next = ST_READ;
            default:                                  state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (!stat.stall) begin
          state_next = stat.last_slot ? ST_FINISH : ST_READ;
        end
      end
      ST_FINISH: begin
        state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!stat.pend_valid || stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_ready  = 1'b0;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        ctl.load  = cmd_valid;
      end
      ST_READ: begin
        ctl.rd_en = 1'b1;
      end
      ST_EVAL: begin
        ctl.eval = !stat.stall;
      end
      ST_FINISH: begin
        ctl.finish = 1'b1;
      end
      ST_FLUSH: begin
        ctl.flush = stat.pend_valid && stat.out_free;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/stt_datapath.sv =====
// ----------------------------------------------------------------------------
// stt_datapath
// Slot storage, scan index, command hold registers, held result and the
// response output register.
// ----------------------------------------------------------------------------
module stt_datapath #(
  parameter int NUM_SLOTS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  stt_pkg::cmd_t  cmd,
  input  stt_pkg::ctl_t  ctl,
  output stt_pkg::stat_t stat,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output stt_pkg::rsp_t  rsp
);
  import stt_pkg::*;

  localparam int IW      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ENTRY_W = 1 + ID_W + TICKS_W;

  // held command
  logic [2:0]          item_action;
  logic [ID_W-1:0]     item_id;
  logic [PERIOD_W-1:0] item_period;
  logic                item_notify;
  logic [TICKS_W-1:0]  ticks_req;
  logic [63:0]         div_prod;

  // slot storage: notify, id, ticks in memory; active bits in flops
  logic [ENTRY_W-1:0]   slot_mem [NUM_SLOTS];
  logic [ENTRY_W-1:0]   rd_data;
  logic [NUM_SLOTS-1:0] active;

  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;

  // scan state
  logic [IW-1:0]        idx;
  logic [IW-1:0]        first_free;
  logic                 found;
  logic [TICKS_W-1:0]   q_ticks;
  logic [EVCNT_W-1:0]   evcnt;

  // held result
  logic                 pend_valid;
  rsp_t                 pend;
  rsp_t                 pend_final;
  rsp_t                 expiry_rsp;

  logic                 rd_notify;
  logic [ID_W-1:0]      rd_id;
  logic [TICKS_W-1:0]   rd_ticks;
  logic                 cur_active;
  logic                 id_hit;
  logic                 is_tick;
  logic                 is_start;
  logic                 is_stop;
  logic                 is_query;
  logic                 expire;
  logic                 need_event;
  logic                 out_free;
  logic                 push_mid;
  logic                 last_slot;
  logic [REM_W-1:0]     q_rem;

  assign is_tick  = (item_action == ACT_TICK);
  assign is_start = (item_action == ACT_START);
  assign is_stop  = (item_action == ACT_STOP);
  assign is_query = (item_action == ACT_QUERY);

  assign rd_notify = rd_data[ENTRY_W-1];
  assign rd_id     = rd_data[TICKS_W +: ID_W];
  assign rd_ticks  = rd_data[TICKS_W-1:0];

  assign cur_active = active[idx];
  assign id_hit     = cur_active && (rd_id == item_id);
  assign expire     = is_tick && cur_active && (rd_ticks <= TICKS_W'(1));
  assign need_event = expire && rd_notify && (evcnt < EVCNT_W'(MAX_EVENTS));
  assign out_free   = !rsp_valid || rsp_ready;
  assign push_mid   = ctl.eval && need_event && pend_valid;
  assign last_slot  = (idx == IW'(NUM_SLOTS - 1));

  assign stat.last_slot  = last_slot;
  assign stat.stall      = need_event && pend_valid && !out_free;
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = out_free;

  // ticks * 10 as shift-add
  assign q_rem = ({3'b000, q_ticks} << 3) + ({3'b000, q_ticks} << 1);

  assign div_prod = item_period * DIV10_MAGIC;

  always_comb begin
    expiry_rsp              = '0;
    expiry_rsp.kind         = KIND_EXPIRY;
    expiry_rsp.event_id     = rd_id;
    expiry_rsp.flag         = 1'b1;
    pend_final              = pend;
    pend_final.last         = 1'b1;
  end

  always_comb begin
    mem_we    = (ctl.eval && is_tick && cur_active && !expire) ||
                (ctl.finish && is_start && found);
    mem_waddr = ctl.finish ? first_free : idx;
    mem_wdata = ctl.finish ? {item_notify, item_id, ticks_req}
                           : {rd_notify, rd_id, rd_ticks - TICKS_W'(1)};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (ctl.rd_en) begin
      rd_data <= slot_mem[idx];
    end
  end

  // command hold and period / 10
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_action <= cmd.action;
      item_id     <= cmd.tmr_id;
      item_period <= cmd.period_ms;
      item_notify <= cmd.notify;
    end
    ticks_req <= div_prod[DIV10_SHIFT +: TICKS_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (ctl.load && (cmd.action == ACT_RESET_ALL)) begin
      active <= '0;
    end else if (ctl.eval && (expire || ((is_start || is_stop) && id_hit))) begin
      active[idx] <= 1'b0;
    end else if (ctl.finish && is_start && found) begin
      active[first_free] <= 1'b1;
    end
  end

  // scan index, first free slot, query hit, event count
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      found <= 1'b0;
      evcnt <= '0;
    end else if (ctl.load) begin
      idx   <= '0;
      found <= 1'b0;
      evcnt <= '0;
    end else if (ctl.eval) begin
      if (!last_slot) begin
        idx <= idx + IW'(1);
      end
      if (need_event) begin
        evcnt <= evcnt + EVCNT_W'(1);
      end
      if (is_start && !found && (!cur_active || id_hit)) begin
        found <= 1'b1;
      end
      if (is_query && !found && id_hit) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval && !found) begin
      if (is_start && (!cur_active || id_hit)) begin
        first_free <= idx;
      end
      if (is_query && id_hit) begin
        q_ticks <= rd_ticks;
      end
    end
  end

  // held result
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (ctl.eval && need_event) begin
      pend_valid <= 1'b1;
    end else if (ctl.finish && (is_start || is_query)) begin
      pend_valid <= 1'b1;
    end else if (ctl.flush) begin
      pend_valid <= 1'b0;
    end
  end

  // a tick keeps its last expiry beat here through finish
  always_ff @(posedge clk) begin
    if (ctl.eval && need_event) begin
      pend <= expiry_rsp;
    end else if (ctl.finish && (is_start || is_query)) begin
      pend.kind         <= is_start ? KIND_START : KIND_QUERY;
      pend.event_id     <= item_id;
      pend.flag         <= found;
      pend.remaining_ms <= (is_query && found) ? q_rem : '0;
      pend.last         <= 1'b0;
    end
  end

  // response output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push_mid || ctl.flush) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid) begin
      rsp <= pend;
    end else if (ctl.flush) begin
      rsp <= pend_final;
    end
  end

endmodule

// ===== rtl/core/software_timer_table_core.sv =====
// ----------------------------------------------------------------------------
// software_timer_table_core
// Sequence: tick, start, stop and query read and evaluate every slot, then pass
//   finish and flush the held result, if any, into the response register, taking
//   longer while rsp_ready is low; reset-all and unknown actions go back to idle.
// Commands: a new command is accepted only in idle, after the slot scan through
//   the slot memory (one read and one evaluate per slot) and the flush.
// Reset: rst clears all slots, the sequencer and the response register.
// ----------------------------------------------------------------------------
module software_timer_table_core #(
  parameter int NUM_SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  stt_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output stt_pkg::rsp_t rsp
);
  import stt_pkg::*;

  // command and status between sequencer and datapath
  ctl_t  ctl;
  stat_t stat;

  // sequencer: idle -> (read, evaluate) per slot -> finish -> flush
  // a tick can raise several expiry beats; each one waits in a holding
  // register until the next shows up, so only the final beat carries last
  stt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_action (cmd.action),
    .stat       (stat),
    .ctl        (ctl)
  );

  // slot table, scan registers, period to tick conversion and the
  // response register that decouples the output from the scan
  stt_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
